FILE: hw/rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  // Opcodes with special handling
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  // Frame status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_PROTO = 2'd1;
  localparam logic [1:0] ST_UTF8  = 2'd2;

  // Seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extended length and key byte counts
  localparam logic [3:0] CNT_EXT16 = 4'd2;
  localparam logic [3:0] CNT_EXT64 = 4'd8;
  localparam logic [3:0] CNT_KEY   = 4'd4;

  // UTF-8 decoder state
  typedef struct packed {
    logic [1:0] need;
    logic [7:0] lead;
    logic [7:0] second;
  } utf8_state_t;

  // One result beat
  typedef struct packed {
    logic [7:0]  data;
    logic        byte_valid;
    logic        last;
    logic        fin;
    logic [3:0]  opcode;
    logic [1:0]  status;
    logic [15:0] close_code;
  } result_t;

  // Reserved opcodes: 3..7 and 11..15
  function automatic logic opcode_reserved(input logic [3:0] op);
    return ((op >= 4'd3) && (op <= 4'd7)) || (op >= 4'd11);
  endfunction

endpackage

FILE: hw/rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input stage, parser, output stage.
//
// Takes one byte per beat and sustains one byte per cycle: a byte is parsed during the cycle
// it sits in the input register, and its result lands in the output register as the stage
// advances. A byte accepted at one clock edge thus passes the input register and the output
// register before its result beat shows on the outputs.
// Header bytes yield no beat; a zero-length frame yields one empty last beat. The output
// register and the input register together let a new byte enter while a finished beat waits
// on out_stall; throughput drops only while the receiver stalls.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_frame_last,
  output logic        out_fin_flag,
  output logic [3:0]  out_frame_opcode,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_close_code
);
  import wsfd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       adv;
  logic       fire;
  logic       in_take;
  logic       res_valid;
  result_t    res;
  logic       out_valid_r;
  result_t    out_r;

  // Stage advances whenever the output slot is free or draining
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
    if (in_take) begin
      s1_byte_r <= in_byte;
    end
  end

  wsfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .b         (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a new beat or hold a stalled one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && res_valid;
    end
    if (adv && fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_frame_last   = out_r.last;
  assign out_fin_flag     = out_r.fin;
  assign out_frame_opcode = out_r.opcode;
  assign out_frame_status = out_r.status;
  assign out_close_code   = out_r.close_code;

endmodule

FILE: hw/rtl/wsfd_utf8.sv
// UTF-8 validator step: checks one text byte against the decoder state.
module wsfd_utf8 (
  input  wsfd_pkg::utf8_state_t st,
  input  logic [7:0]            b,
  output logic                  ok,
  output wsfd_pkg::utf8_state_t st_nxt
);
  import wsfd_pkg::*;

  logic [1:0] total;
  logic       second;

  // Continuation bytes implied by the lead byte
  always_comb begin
    if ((st.lead & 8'hF0) == 8'hE0) begin
      total = 2'd2;
    end else if ((st.lead & 8'hF8) == 8'hF0) begin
      total = 2'd3;
    end else begin
      total = 2'd1;
    end
    second = (st.need == total);
  end

  // Check the byte and advance the decoder
  always_comb begin
    ok     = 1'b1;
    st_nxt = st;
    if (st.need == 2'd0) begin
      st_nxt.lead = b;
      if (b == 8'h00) begin
        ok = 1'b0;
      end else if (b < 8'h80) begin
        ok = 1'b1;
      end else if ((b & 8'hE0) == 8'hC0) begin
        if ((b & 8'hFE) == 8'hC0) begin
          ok = 1'b0;
        end else begin
          st_nxt.need = 2'd1;
        end
      end else if ((b & 8'hF0) == 8'hE0) begin
        st_nxt.need = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
        if (b > 8'hF4) begin
          ok = 1'b0;
        end else begin
          st_nxt.need = 2'd3;
        end
      end else begin
        ok = 1'b0;
      end
    end else if ((b & 8'hC0) != 8'h80) begin
      ok = 1'b0;
    end else begin
      if (second) begin
        st_nxt.second = b;
        // Reject overlong, surrogate and out-of-range forms
        if ((st.lead == 8'hE0) && ((b & 8'hE0) == 8'h80)) ok = 1'b0;
        if ((st.lead == 8'hED) && ((b & 8'hE0) == 8'hA0)) ok = 1'b0;
        if ((st.lead == 8'hF0) && ((b & 8'hF0) == 8'h80)) ok = 1'b0;
        if ((st.lead == 8'hF4) && (b > 8'h8F)) ok = 1'b0;
      end else if (total == 2'd2) begin
        // Reject the two noncharacters at the top of the basic plane
        if ((st.lead == 8'hEF) && (st.second == 8'hBF) && ((b & 8'hFE) == 8'hBE)) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        st_nxt.need = st.need - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/wsfd_parser.sv
// Frame parser: header decode, unmasking, close code and text check per byte.
module wsfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        b,
  output logic              res_valid,
  output wsfd_pkg::result_t res
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hcount_r, hcount_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  utf8_state_t utf_r, utf_nxt, utf_step;
  logic [15:0] close_r, close_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  status_r, status_nxt;

  logic [7:0]  key_byte;
  logic [7:0]  data;
  logic        utf_ok;
  logic [3:0]  hcount_dec;
  logic [63:0] ext_len;

  // Key byte for the current payload position
  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    data = masked_r ? (b ^ key_byte) : b;
  end

  wsfd_utf8 u_utf8 (
    .st     (utf_r),
    .b      (data),
    .ok     (utf_ok),
    .st_nxt (utf_step)
  );

  assign hcount_dec = hcount_r - 4'd1;
  assign ext_len    = {rem_r[55:0], b};

  // Next state and result for one byte
  always_comb begin
    phase_nxt  = phase_r;
    hcount_nxt = hcount_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    utf_nxt    = utf_r;
    close_nxt  = close_r;
    pos_nxt    = pos_r;
    status_nxt = status_r;
    res_valid  = 1'b0;
    res        = '0;

    unique case (phase_r)
      PH_HDR0: begin
        hcount_nxt = '0;
        masked_nxt = 1'b0;
        rem_nxt    = '0;
        key_nxt    = '0;
        kidx_nxt   = '0;
        utf_nxt    = '0;
        close_nxt  = '0;
        pos_nxt    = '0;
        status_nxt = ST_OK;
        fin_nxt    = b[7];
        opcode_nxt = b[3:0];
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = b[7];
        if (b[6:0] == LEN_EXT16) begin
          rem_nxt    = '0;
          hcount_nxt = CNT_EXT16;
          phase_nxt  = PH_EXTLEN;
        end else if (b[6:0] == LEN_EXT64) begin
          rem_nxt    = '0;
          hcount_nxt = CNT_EXT64;
          phase_nxt  = PH_EXTLEN;
        end else begin
          rem_nxt = {57'd0, b[6:0]};
          if (b[7]) begin
            hcount_nxt = CNT_KEY;
            phase_nxt  = PH_KEY;
          end else begin
            status_nxt = opcode_reserved(opcode_r) ? ST_PROTO : ST_OK;
            phase_nxt  = (b[6:0] == 7'd0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        rem_nxt    = ext_len;
        hcount_nxt = hcount_dec;
        if (hcount_dec == 4'd0) begin
          if (masked_r) begin
            hcount_nxt = CNT_KEY;
            phase_nxt  = PH_KEY;
          end else begin
            status_nxt = opcode_reserved(opcode_r) ? ST_PROTO : ST_OK;
            phase_nxt  = (ext_len == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        key_nxt    = {key_r[23:0], b};
        hcount_nxt = hcount_dec;
        if (hcount_dec == 4'd0) begin
          status_nxt = opcode_reserved(opcode_r) ? ST_PROTO : ST_OK;
          phase_nxt  = (rem_r == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (masked_r) kidx_nxt = kidx_r + 2'd1;
        if ((opcode_r == OP_CLOSE) && (pos_r < 2'd2)) begin
          close_nxt = {close_r[7:0], data};
          pos_nxt   = pos_r + 2'd1;
        end
        if ((opcode_r == OP_TEXT) && (status_r == ST_OK)) begin
          utf_nxt = utf_step;
          if (!utf_ok) status_nxt = ST_UTF8;
        end
        rem_nxt = rem_r - 64'd1;
        if (rem_r == 64'd1) begin
          phase_nxt = PH_HDR0;
          // Flag a sequence cut off at the frame end
          if ((opcode_r == OP_TEXT) && (status_nxt == ST_OK) && (utf_nxt.need != 2'd0)) begin
            status_nxt = ST_UTF8;
          end
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    // Build the result beat
    if (phase_r == PH_PAYLOAD) begin
      res_valid      = 1'b1;
      res.data       = data;
      res.byte_valid = 1'b1;
      res.last       = (rem_r == 64'd1);
      if (res.last && (opcode_r == OP_CLOSE) && (pos_nxt == 2'd2)) begin
        res.close_code = close_nxt;
      end
    end else if ((phase_r != PH_HDR0) && (phase_nxt == PH_HDR0)) begin
      res_valid = 1'b1;
      res.last  = 1'b1;
    end
    res.fin    = fin_r;
    res.opcode = opcode_r;
    res.status = status_nxt;
  end

  // Hold frame state; advance on each byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
    if (fire) begin
      hcount_r <= hcount_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      utf_r    <= utf_nxt;
      close_r  <= close_nxt;
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A first header byte never yields a result
  a_hdr0_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (phase_r == PH_HDR0)) |-> !res_valid)
    else $error("result on first header byte");

  // The empty marker is always the last beat of its frame
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.byte_valid) |-> res.last)
    else $error("empty marker not last");

  // Close code only shows on the last beat
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.last) |-> (res.close_code == 16'd0))
    else $error("close code on non-last beat");

  // After the last beat the parser looks for a new header
  a_back_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && res.last) |=> (phase_r == PH_HDR0))
    else $error("no return to header after last beat");
`endif

endmodule

FILE: dv/tb_websocket_frame_deframer.sv
// Self-checking testbench for the WebSocket frame deframer: frame stimulus, prediction, checks.
module tb_websocket_frame_deframer;
  import wsfd_pkg::*;

  // Opcodes without special handling, and the ends of the two reserved ranges
  localparam logic [3:0] OPC_CONT    = 4'h0;
  localparam logic [3:0] OPC_BIN     = 4'h2;
  localparam logic [3:0] OPC_PING    = 4'h9;
  localparam logic [3:0] OPC_PONG    = 4'hA;
  localparam logic [3:0] OPC_RSV_A   = 4'h3;
  localparam logic [3:0] OPC_RSV_B   = 4'hB;
  localparam logic [3:0] OPC_RSV_TOP = 4'hF;

  localparam int RANDOM_BYTES = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {LK_SHORT, LK_EXT16, LK_EXT64} len_kind_t;
  typedef enum logic [2:0] {RX_HDR0, RX_HDR1, RX_EXTLEN, RX_KEY, RX_PAYLOAD} rx_phase_t;

  // Predicts deframed beats from accepted bytes and matches them against the block
  class deframe_checker;
    rx_phase_t   phase;
    logic [3:0]  hdr_left;
    logic        fin;
    logic        masked;
    logic [3:0]  opcode;
    logic [63:0] len_left;
    logic [31:0] key;
    logic [1:0]  key_pos;
    logic [1:0]  u_need;
    logic [7:0]  u_lead;
    logic [7:0]  u_second;
    logic [15:0] close_acc;
    logic [1:0]  close_cnt;
    logic [1:0]  status;
    result_t     beats_due[$];
    int          errors;
    int          beats_seen;
    int          bad_frames;

    function new();
      phase      = RX_HDR0;
      fin        = 1'b0;
      opcode     = '0;
      errors     = 0;
      beats_seen = 0;
      bad_frames = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_left  = '0;
      masked    = 1'b0;
      len_left  = '0;
      key       = '0;
      key_pos   = '0;
      u_need    = '0;
      u_lead    = '0;
      u_second  = '0;
      close_acc = '0;
      close_cnt = '0;
      status    = ST_OK;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void push_beat(logic [7:0] data, logic bv, logic last, logic [15:0] code);
      result_t r;
      r.data       = data;
      r.byte_valid = bv;
      r.last       = last;
      r.fin        = fin;
      r.opcode     = opcode;
      r.status     = status;
      r.close_code = code;
      beats_due.push_back(r);
    endfunction

    // Return 1 while the text stays valid UTF-8
    function bit utf8_ok(logic [7:0] b);
      int total;
      if (u_need == 0) begin
        u_lead = b;
        if (b == 8'h00) return 1'b0;
        if (b < 8'h80) return 1'b1;
        if ((b & 8'hE0) == 8'hC0) begin
          if ((b & 8'hFE) == 8'hC0) return 1'b0;
          u_need = 2'd1;
          return 1'b1;
        end
        if ((b & 8'hF0) == 8'hE0) begin
          u_need = 2'd2;
          return 1'b1;
        end
        if ((b & 8'hF8) == 8'hF0) begin
          if (b > 8'hF4) return 1'b0;
          u_need = 2'd3;
          return 1'b1;
        end
        return 1'b0;
      end
      if ((b & 8'hC0) != 8'h80) return 1'b0;
      total = ((u_lead & 8'hF0) == 8'hE0) ? 2 : ((u_lead & 8'hF8) == 8'hF0) ? 3 : 1;
      if (int'(u_need) == total) begin
        // second byte: overlong, surrogate and range limits
        u_second = b;
        if (u_lead == 8'hE0 && (b & 8'hE0) == 8'h80) return 1'b0;
        if (u_lead == 8'hED && (b & 8'hE0) == 8'hA0) return 1'b0;
        if (u_lead == 8'hF0 && (b & 8'hF0) == 8'h80) return 1'b0;
        if (u_lead == 8'hF4 && b > 8'h8F) return 1'b0;
      end else if (total == 2) begin
        // third byte of a three-byte form: reject the two noncharacters at the plane end
        if (u_lead == 8'hEF && u_second == 8'hBF && (b & 8'hFE) == 8'hBE) return 1'b0;
      end
      u_need = u_need - 2'd1;
      return 1'b1;
    endfunction

    // Header finished: mark an empty frame or move on to the payload
    function void header_end();
      status = (((opcode >= OPC_RSV_A) && (opcode < OP_CLOSE)) || (opcode >= OPC_RSV_B)) ?
               ST_PROTO : ST_OK;
      if (len_left == 0) begin
        push_beat(8'h00, 1'b0, 1'b1, 16'h0000);
        phase = RX_HDR0;
      end else begin
        phase = RX_PAYLOAD;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0]  data;
      logic        last;
      logic [15:0] code;
      case (phase)
        RX_HDR0: begin
          clear_frame();
          fin    = b[7];
          opcode = b[3:0];
          phase  = RX_HDR1;
        end
        RX_HDR1: begin
          masked   = b[7];
          len_left = '0;
          if (b[6:0] == LEN_EXT16) begin
            hdr_left = CNT_EXT16;
            phase    = RX_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            hdr_left = CNT_EXT64;
            phase    = RX_EXTLEN;
          end else begin
            len_left = 64'(b[6:0]);
            if (masked) begin
              hdr_left = CNT_KEY;
              phase    = RX_KEY;
            end else begin
              header_end();
            end
          end
        end
        RX_EXTLEN: begin
          len_left = {len_left[55:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) begin
            if (masked) begin
              hdr_left = CNT_KEY;
              phase    = RX_KEY;
            end else begin
              header_end();
            end
          end
        end
        RX_KEY: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) header_end();
        end
        default: begin
          // unmask, track the close code and the text check, count down the length
          data = b;
          code = 16'h0000;
          if (masked) begin
            data    = data ^ key[8*(3 - int'(key_pos)) +: 8];
            key_pos = key_pos + 2'd1;
          end
          if (opcode == OP_CLOSE && close_cnt < 2) begin
            close_acc = {close_acc[7:0], data};
            close_cnt = close_cnt + 2'd1;
          end
          if (opcode == OP_TEXT && status == ST_OK && !utf8_ok(data)) status = ST_UTF8;
          len_left = len_left - 64'd1;
          last     = (len_left == 0);
          if (last) begin
            if (opcode == OP_TEXT && status == ST_OK && u_need != 0) status = ST_UTF8;
            if (opcode == OP_CLOSE && close_cnt >= 2) code = close_acc;
            phase = RX_HDR0;
          end
          push_beat(data, 1'b1, last, code);
        end
      endcase
    endfunction

    function void field(string name, logic [15:0] exp, logic [15:0] act);
      if (exp !== act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void match_beat(result_t got);
      result_t exp;
      if (beats_due.size() == 0) begin
        $error("unexpected beat: out_byte %0h, nothing pending", got.data);
        errors++;
        return;
      end
      exp = beats_due.pop_front();
      beats_seen++;
      if (exp.last && exp.status != ST_OK) bad_frames++;
      field("out_byte",         16'(exp.data),       16'(got.data));
      field("out_byte_valid",   16'(exp.byte_valid), 16'(got.byte_valid));
      field("out_frame_last",   16'(exp.last),       16'(got.last));
      field("out_fin_flag",     16'(exp.fin),        16'(got.fin));
      field("out_frame_opcode", 16'(exp.opcode),     16'(got.opcode));
      field("out_frame_status", 16'(exp.status),     16'(got.status));
      field("out_close_code",   exp.close_code,      got.close_code);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_frame_last;
  logic        out_fin_flag;
  logic [3:0]  out_frame_opcode;
  logic [1:0]  out_frame_status;
  logic [15:0] out_close_code;

  deframe_checker sb = new();
  logic [7:0]     payload[$];
  bit             calm = 1'b0;
  int             bytes_sent = 0;
  int             frames_sent = 0;
  int             quiet_cycles = 0;

  websocket_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_last   (out_frame_last),
    .out_fin_flag     (out_fin_flag),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_status (out_frame_status),
    .out_close_code   (out_close_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.data       = out_byte;
      got.byte_valid = out_byte_valid;
      got.last       = out_frame_last;
      got.fin        = out_fin_flag;
      got.opcode     = out_frame_opcode;
      got.status     = out_frame_status;
      got.close_code = out_close_code;
      sb.match_beat(got);
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved in %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
    calm = (bytes_sent >= 600) && (bytes_sent < 1000);
  endtask

  // Send header, optional extended length, optional key and the payload queue, masked when asked
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic msk,
                            input len_kind_t kind, input logic [63:0] len);
    logic [31:0] mkey;
    logic [6:0]  len7;
    mkey = $urandom;
    len7 = (kind == LK_SHORT) ? len[6:0] : (kind == LK_EXT16) ? LEN_EXT16 : LEN_EXT64;
    send_byte({fin, 3'($urandom_range(7)), op});
    send_byte({msk, len7});
    if (kind == LK_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (kind == LK_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (msk) begin
      for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
    end
    foreach (payload[i]) begin
      send_byte(msk ? payload[i] ^ mkey[8*(3 - (i % 4)) +: 8] : payload[i]);
    end
    frames_sent++;
  endtask

  task automatic send_plain(input logic [3:0] op, input logic msk);
    send_frame(1'b1, op, msk, LK_SHORT, 64'(payload.size()));
  endtask

  function automatic void push_codepoint(int unsigned cp);
    if (cp < 32'h80) begin
      payload.push_back(8'(cp));
    end else if (cp < 32'h800) begin
      payload.push_back(8'hC0 | 8'(cp >> 6));
      payload.push_back(8'h80 | 8'(cp & 32'h3F));
    end else if (cp < 32'h10000) begin
      payload.push_back(8'hE0 | 8'(cp >> 12));
      payload.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
      payload.push_back(8'h80 | 8'(cp & 32'h3F));
    end else begin
      payload.push_back(8'hF0 | 8'(cp >> 18));
      payload.push_back(8'h80 | 8'((cp >> 12) & 32'h3F));
      payload.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
      payload.push_back(8'h80 | 8'(cp & 32'h3F));
    end
  endfunction

  // Fill the payload with mostly valid text, cut to length, now and then corrupted
  function automatic void build_text(int n);
    int pick;
    payload.delete();
    while (payload.size() < n) begin
      pick = $urandom_range(99);
      if (pick < 50)      push_codepoint($urandom_range(32'h7F, 32'h1));
      else if (pick < 70) push_codepoint($urandom_range(32'h7FF, 32'h80));
      else if (pick < 88) push_codepoint($urandom_range(32'hFFFF, 32'h800));
      else                push_codepoint($urandom_range(32'h10FFFF, 32'h10000));
    end
    while (payload.size() > n) payload.pop_back();
    if (n > 0 && $urandom_range(9) == 0) payload[$urandom_range(n - 1)] = 8'($urandom);
  endfunction

  function automatic void build_random(int n);
    payload.delete();
    repeat (n) payload.push_back(8'($urandom));
  endfunction

  task automatic random_frame();
    int          n;
    int          pick;
    logic [3:0]  op;
    len_kind_t   kind;
    pick = $urandom_range(99);
    if (pick < 35)      op = OP_TEXT;
    else if (pick < 50) op = OPC_BIN;
    else if (pick < 60) op = OPC_CONT;
    else if (pick < 72) op = OP_CLOSE;
    else if (pick < 80) op = OPC_PING;
    else if (pick < 88) op = OPC_PONG;
    else begin
      pick = $urandom_range(9);
      op   = (pick < 5) ? OPC_RSV_A + 4'(pick) : OPC_RSV_B + 4'(pick - 5);
    end
    pick = $urandom_range(99);
    if (pick < 55)      n = $urandom_range(8);
    else if (pick < 92) n = $urandom_range(40, 9);
    else                n = $urandom_range(300, 126);
    pick = $urandom_range(99);
    if (n > 125 || pick < 12) kind = LK_EXT16;
    else if (pick < 20)       kind = LK_EXT64;
    else                      kind = LK_SHORT;
    if (op == OP_TEXT || op == OP_CLOSE) build_text(n);
    else                                 build_random(n);
    if (op == OP_CLOSE && n >= 2) begin
      payload[0] = 8'($urandom);
      payload[1] = 8'($urandom);
    end
    send_frame(1'($urandom), op, 1'($urandom), kind, 64'(n));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty frames, byte extremes, every opcode class, text failures, close codes
    payload.delete();
    send_plain(OP_TEXT, 1'b0);
    send_frame(1'b1, OPC_BIN, 1'b1, LK_EXT16, 64'd0);
    payload = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_plain(OPC_BIN, 1'b1);
    send_frame(1'b0, OPC_CONT, 1'b0, LK_EXT16, 64'd4);
    send_frame(1'b1, OPC_PING, 1'b1, LK_EXT64, 64'd4);
    payload = '{8'h68, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9D, 8'h84, 8'h9E};
    send_plain(OP_TEXT, 1'b1);
    // text that must fail: NUL, stray continuation, lead above F4, overlong forms
    payload = '{8'h41, 8'h00};             send_plain(OP_TEXT, 1'b0);
    payload = '{8'h80};                    send_plain(OP_TEXT, 1'b1);
    payload = '{8'hF5, 8'h80};             send_plain(OP_TEXT, 1'b0);
    payload = '{8'hC1, 8'hBF};             send_plain(OP_TEXT, 1'b0);
    payload = '{8'hE0, 8'h80, 8'h80};      send_plain(OP_TEXT, 1'b1);
    payload = '{8'hF0, 8'h80, 8'h80, 8'h80}; send_plain(OP_TEXT, 1'b0);
    // surrogate, noncharacters at the plane end, beyond the code space
    payload = '{8'hED, 8'hA0, 8'h80};      send_plain(OP_TEXT, 1'b0);
    payload = '{8'hEF, 8'hBF, 8'hBE};      send_plain(OP_TEXT, 1'b1);
    payload = '{8'hEF, 8'hBF, 8'hBF};      send_plain(OP_TEXT, 1'b0);
    payload = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_plain(OP_TEXT, 1'b0);
    // bad continuation byte and a sequence cut off at the frame end
    payload = '{8'hC3, 8'h41};             send_plain(OP_TEXT, 1'b0);
    payload = '{8'hE2, 8'h82};             send_plain(OP_TEXT, 1'b1);
    // close frames: full code with reason, full code alone, one byte, none
    payload = '{8'h03, 8'hE8, 8'h62, 8'h79}; send_plain(OP_CLOSE, 1'b1);
    payload = '{8'hFF, 8'hFF};             send_plain(OP_CLOSE, 1'b0);
    payload = '{8'h03};                    send_plain(OP_CLOSE, 1'b0);
    payload.delete();                      send_plain(OP_CLOSE, 1'b1);
    // reserved opcodes at the bottom of the first range and the top of the second, and a pong
    payload = '{8'h00, 8'hC0};             send_plain(OPC_RSV_A, 1'b0);
    payload = '{8'h11};                    send_plain(OPC_RSV_TOP, 1'b1);
    payload = '{8'h5A, 8'hA5};             send_plain(OPC_PONG, 1'b0);

    // Random frames with random idling on both sides
    while (bytes_sent < RANDOM_BYTES) random_frame();

    // End with a binary frame of huge announced length; its payload never ends
    build_random(40);
    send_frame(1'b1, OPC_BIN, 1'b1, LK_EXT64, 64'hFFFF_FFFF_FFFF_FFFF);
    in_valid <= 1'b0;

    // Drain the expected beats, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d frames in %0d bytes; checked %0d beats, %0d frames ended in error.",
             frames_sent, bytes_sent, sb.beats_seen, sb.bad_frames);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
